// ===== design/cgru_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the CG residual update unit.
// Used by cgru_ctrl, cgru_dp and cg_residual_update_three_dots_unit; no dependencies.
package cgru_pkg;

  localparam int FRAC_BITS  = 24;
  localparam int DATA_W     = 32;
  localparam int WEIGHT_W   = 25;
  localparam int ACC_W      = 64;
  localparam int CFG_IDX_W  = 8;
  localparam int PROD_W     = 64;
  localparam int RND_W      = 40;   // rounded product of two Q8.24 values
  localparam int MUL_A_W    = 40;
  localparam int MUL_B_W    = 33;

  localparam logic [WEIGHT_W-1:0]  ONE_Q24  = WEIGHT_W'(25'd16777216);
  localparam logic [PROD_W-1:0]    HALF_Q24 = PROD_W'(64'd8388608);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_STEP = CFG_IDX_W'(8'd0);
  localparam logic [CFG_IDX_W-1:0] CFG_USE_WEIGHT = CFG_IDX_W'(8'd1);

  typedef enum logic [10:0] {
    ST_IDLE = 11'b000_0000_0001,
    ST_AS   = 11'b000_0000_0010,
    ST_AZ   = 11'b000_0000_0100,
    ST_PRR  = 11'b000_0000_1000,
    ST_PRZ  = 11'b000_0001_0000,
    ST_PZZ  = 11'b000_0010_0000,
    ST_WRR  = 11'b000_0100_0000,
    ST_WRZ  = 11'b000_1000_0000,
    ST_WZZ  = 11'b001_0000_0000,
    ST_TZZ  = 11'b010_0000_0000,
    ST_OUT  = 11'b100_0000_0000
  } state_t;

  typedef enum logic [3:0] {
    MUL_NONE,
    MUL_ALPHA_S,
    MUL_ALPHA_SS,
    MUL_RN_RN,
    MUL_RN_ZN,
    MUL_ZN_ZN,
    MUL_PRR_W,
    MUL_PRZ_W,
    MUL_PZZ_W
  } mul_sel_t;

  typedef enum logic [1:0] {
    ACC_NONE,
    ACC_RR,
    ACC_RZ,
    ACC_ZZ
  } acc_sel_t;

  typedef struct packed {
    logic     cap_in;
    mul_sel_t mul_sel;
    logic     ld_rn;
    logic     ld_zn;
    logic     ld_prr;
    logic     ld_prz;
    logic     ld_pzz;
    logic     ld_term;
    acc_sel_t acc_sel;
    logic     ld_out;
  } dp_cmd_t;

endpackage

// ===== design/cg_residual_update_three_dots_unit.sv =====
`timescale 1ns / 1ps
// CG residual update with three fused weighted dot products (r.z, z.z, r.r), Q8.24 data.
// A new input is taken only once the sequencer has loaded the previous result into the output
//   register, as the single shared 40x33 multiplier issues eight products per element in turn.
// A held result does not block the next input transaction; the output register parts them.
// Reset (rst_n low, synchronous): sequencer idle, no result pending, accumulators and
//   configuration (alpha_step, use_weight) cleared to zero.
module cg_residual_update_three_dots_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  // input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [cgru_pkg::DATA_W-1:0]  in_resid_in,
  input  logic signed [cgru_pkg::DATA_W-1:0]  in_precond_in,
  input  logic signed [cgru_pkg::DATA_W-1:0]  in_dir_prod_in,
  input  logic signed [cgru_pkg::DATA_W-1:0]  in_precond_dir_prod_in,
  input  logic        [cgru_pkg::WEIGHT_W-1:0] in_node_weight,
  input  logic                                in_last_in,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [cgru_pkg::DATA_W-1:0]  out_resid_out,
  output logic signed [cgru_pkg::DATA_W-1:0]  out_precond_out,
  output logic signed [cgru_pkg::ACC_W-1:0]   out_sum_rz,
  output logic signed [cgru_pkg::ACC_W-1:0]   out_sum_zz,
  output logic signed [cgru_pkg::ACC_W-1:0]   out_sum_rr,
  output logic                                out_last_out,
  // configuration write channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic        [cgru_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic        [cgru_pkg::DATA_W-1:0]  cfg_data
);

  cgru_pkg::dp_cmd_t cmd;

  // configuration is always taken; writes to unknown indexes are dropped in the datapath
  assign cfg_ready = 1'b1;

  // sequencer: accepts a transaction when idle, then walks the multiply schedule:
  //   alpha*s, alpha*S, r'*r', r'*z', z'*z', then the three weight products,
  //   with each product registered, then rounded, and the weighted terms accumulated after rounding
  cgru_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // datapath: operand capture, shared multiplier, Q.24 rounding and saturation,
  // the three saturating accumulators and the output register
  cgru_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .cfg_we              (cfg_valid & cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .resid_in            (in_resid_in),
    .precond_in          (in_precond_in),
    .dir_prod_in         (in_dir_prod_in),
    .precond_dir_prod_in (in_precond_dir_prod_in),
    .node_weight         (in_node_weight),
    .last_in             (in_last_in),
    .resid_out           (out_resid_out),
    .precond_out         (out_precond_out),
    .sum_rz              (out_sum_rz),
    .sum_zz              (out_sum_zz),
    .sum_rr              (out_sum_rr),
    .last_out            (out_last_out)
  );

endmodule

// ===== design/cgru_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencer for the CG residual update unit: steps the shared multiplier and owns both handshakes.
// Depends on cgru_pkg.
module cgru_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  output cgru_pkg::dp_cmd_t cmd
);

  cgru_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;

  assign in_stall  = (state_r != cgru_pkg::ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    cmd.mul_sel = cgru_pkg::MUL_NONE;
    cmd.acc_sel = cgru_pkg::ACC_NONE;
    unique case (state_r)
      cgru_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.cap_in = 1'b1;
          state_nxt  = cgru_pkg::ST_AS;
        end
      end
      cgru_pkg::ST_AS: begin
        cmd.mul_sel = cgru_pkg::MUL_ALPHA_S;
        state_nxt   = cgru_pkg::ST_AZ;
      end
      cgru_pkg::ST_AZ: begin
        cmd.ld_rn   = 1'b1;
        cmd.mul_sel = cgru_pkg::MUL_ALPHA_SS;
        state_nxt   = cgru_pkg::ST_PRR;
      end
      cgru_pkg::ST_PRR: begin
        cmd.ld_zn   = 1'b1;
        cmd.mul_sel = cgru_pkg::MUL_RN_RN;
        state_nxt   = cgru_pkg::ST_PRZ;
      end
      cgru_pkg::ST_PRZ: begin
        cmd.ld_prr  = 1'b1;
        cmd.mul_sel = cgru_pkg::MUL_RN_ZN;
        state_nxt   = cgru_pkg::ST_PZZ;
      end
      cgru_pkg::ST_PZZ: begin
        cmd.ld_prz  = 1'b1;
        cmd.mul_sel = cgru_pkg::MUL_ZN_ZN;
        state_nxt   = cgru_pkg::ST_WRR;
      end
      cgru_pkg::ST_WRR: begin
        cmd.ld_pzz  = 1'b1;
        cmd.mul_sel = cgru_pkg::MUL_PRR_W;
        state_nxt   = cgru_pkg::ST_WRZ;
      end
      cgru_pkg::ST_WRZ: begin
        cmd.ld_term = 1'b1;
        cmd.mul_sel = cgru_pkg::MUL_PRZ_W;
        state_nxt   = cgru_pkg::ST_WZZ;
      end
      cgru_pkg::ST_WZZ: begin
        cmd.acc_sel = cgru_pkg::ACC_RR;
        cmd.ld_term = 1'b1;
        cmd.mul_sel = cgru_pkg::MUL_PZZ_W;
        state_nxt   = cgru_pkg::ST_TZZ;
      end
      cgru_pkg::ST_TZZ: begin
        cmd.acc_sel = cgru_pkg::ACC_RZ;
        cmd.ld_term = 1'b1;
        state_nxt   = cgru_pkg::ST_OUT;
      end
      cgru_pkg::ST_OUT: begin
        // hold until the output register is free
        if (!out_valid_r || !out_stall) begin
          cmd.acc_sel = cgru_pkg::ACC_ZZ;
          cmd.ld_out  = 1'b1;
          state_nxt   = cgru_pkg::ST_IDLE;
        end
      end
      default: state_nxt = cgru_pkg::ST_IDLE;
    endcase
  end

  // the last accumulate and the output load share the ST_OUT cycle; the datapath
  // folds the zz term into the sum it loads
  always_comb begin
    out_valid_nxt = cmd.ld_out | (out_valid_r & out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cgru_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == cgru_pkg::ST_AS))
    else $error("accepted transaction did not start the sequence");

  a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == cgru_pkg::ST_OUT))
    else $error("result raised outside the output step");

  a_out_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == cgru_pkg::ST_OUT && out_valid_r && out_stall) |=>
      (state_r == cgru_pkg::ST_OUT))
    else $error("output step left while the previous result was still held");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == cgru_pkg::ST_OUT) |-> in_stall)
    else $error("input taken while an item is in flight");

endmodule

// ===== design/cgru_dp.sv =====
`timescale 1ns / 1ps
// Datapath of the CG residual update unit: shared multiplier, rounding, saturation,
// accumulators, configuration registers and the output register. Depends on cgru_pkg.
module cgru_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  cgru_pkg::dp_cmd_t                   cmd,
  input  logic                                cfg_we,
  input  logic        [cgru_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic        [cgru_pkg::DATA_W-1:0]  cfg_data,
  input  logic signed [cgru_pkg::DATA_W-1:0]  resid_in,
  input  logic signed [cgru_pkg::DATA_W-1:0]  precond_in,
  input  logic signed [cgru_pkg::DATA_W-1:0]  dir_prod_in,
  input  logic signed [cgru_pkg::DATA_W-1:0]  precond_dir_prod_in,
  input  logic        [cgru_pkg::WEIGHT_W-1:0] node_weight,
  input  logic                                last_in,
  output logic signed [cgru_pkg::DATA_W-1:0]  resid_out,
  output logic signed [cgru_pkg::DATA_W-1:0]  precond_out,
  output logic signed [cgru_pkg::ACC_W-1:0]   sum_rz,
  output logic signed [cgru_pkg::ACC_W-1:0]   sum_zz,
  output logic signed [cgru_pkg::ACC_W-1:0]   sum_rr,
  output logic                                last_out
);

  localparam int DW = cgru_pkg::DATA_W;
  localparam int AW = cgru_pkg::ACC_W;
  localparam int PW = cgru_pkg::PROD_W;
  localparam int RW = cgru_pkg::RND_W;
  localparam int FB = cgru_pkg::FRAC_BITS;

  // configuration
  logic signed [DW-1:0] alpha_r;
  logic                 use_weight_r;

  // captured item
  logic signed [DW-1:0]                  r_r, z_r, s_r, ss_r;
  logic        [cgru_pkg::WEIGHT_W-1:0]  w_r;
  logic                                  last_r;

  // working registers
  logic signed [DW-1:0] rn_r, zn_r;
  logic signed [PW-1:0] prod_r;
  logic signed [RW-1:0] prr_r, prz_r, pzz_r, term_r;
  logic signed [AW-1:0] acc_rz_r, acc_zz_r, acc_rr_r;

  // output register
  logic signed [DW-1:0] resid_out_r, precond_out_r;
  logic signed [AW-1:0] sum_rz_r, sum_zz_r, sum_rr_r;
  logic                 last_out_r;

  logic        [cgru_pkg::WEIGHT_W-1:0]       w_eff;
  logic signed [cgru_pkg::MUL_A_W-1:0]        mul_a;
  logic signed [cgru_pkg::MUL_B_W-1:0]        mul_b;
  logic signed [cgru_pkg::MUL_A_W+cgru_pkg::MUL_B_W-1:0] mul_full;
  logic signed [DW-1:0]  ax_x;
  logic signed [PW:0]    ax_wide;
  logic signed [PW-FB:0] ax_q;
  logic signed [DW-1:0]  ax_sat;
  logic signed [PW-1:0]  rnd;
  logic signed [RW-1:0]  prod_rnd;
  logic signed [AW-1:0]  acc_cur;
  logic signed [AW:0]    acc_sum;
  logic signed [AW-1:0]  acc_new;

  // clamp the weight to one; weight one when weighting is off
  always_comb begin
    if (!use_weight_r) begin
      w_eff = cgru_pkg::ONE_Q24;
    end else if (node_weight > cgru_pkg::ONE_Q24) begin
      w_eff = cgru_pkg::ONE_Q24;
    end else begin
      w_eff = node_weight;
    end
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.mul_sel)
      cgru_pkg::MUL_ALPHA_S: begin
        mul_a = RW'(alpha_r);
        mul_b = cgru_pkg::MUL_B_W'(s_r);
      end
      cgru_pkg::MUL_ALPHA_SS: begin
        mul_a = RW'(alpha_r);
        mul_b = cgru_pkg::MUL_B_W'(ss_r);
      end
      cgru_pkg::MUL_RN_RN: begin
        mul_a = RW'(rn_r);
        mul_b = cgru_pkg::MUL_B_W'(rn_r);
      end
      cgru_pkg::MUL_RN_ZN: begin
        mul_a = RW'(rn_r);
        mul_b = cgru_pkg::MUL_B_W'(zn_r);
      end
      cgru_pkg::MUL_ZN_ZN: begin
        mul_a = RW'(zn_r);
        mul_b = cgru_pkg::MUL_B_W'(zn_r);
      end
      cgru_pkg::MUL_PRR_W: begin
        mul_a = prr_r;
        mul_b = $signed({{(cgru_pkg::MUL_B_W-cgru_pkg::WEIGHT_W){1'b0}}, w_r});
      end
      cgru_pkg::MUL_PRZ_W: begin
        mul_a = prz_r;
        mul_b = $signed({{(cgru_pkg::MUL_B_W-cgru_pkg::WEIGHT_W){1'b0}}, w_r});
      end
      cgru_pkg::MUL_PZZ_W: begin
        mul_a = pzz_r;
        mul_b = $signed({{(cgru_pkg::MUL_B_W-cgru_pkg::WEIGHT_W){1'b0}}, w_r});
      end
      cgru_pkg::MUL_NONE: begin
        mul_a = '0;
        mul_b = '0;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_full = mul_a * mul_b;
  end

  // x - alpha*y: x placed at Q.48 with the rounding half folded into the low bits
  always_comb begin
    ax_x    = cmd.ld_rn ? r_r : z_r;
    ax_wide = $signed({{(PW+1-DW-FB){ax_x[DW-1]}}, ax_x, 1'b1, {(FB-1){1'b0}}})
              - $signed({prod_r[PW-1], prod_r});
    ax_q    = ax_wide[PW:FB];
    if (ax_q > $signed((PW-FB+1)'({1'b0, {(DW-1){1'b1}}}))) begin
      ax_sat = {1'b0, {(DW-1){1'b1}}};
    end else if (ax_q < $signed({{(PW-FB+1-DW){1'b1}}, 1'b1, {(DW-1){1'b0}}})) begin
      ax_sat = {1'b1, {(DW-1){1'b0}}};
    end else begin
      ax_sat = ax_q[DW-1:0];
    end
  end

  // round a Q.48 product to Q.24
  always_comb begin
    rnd      = prod_r + $signed(cgru_pkg::HALF_Q24);
    prod_rnd = rnd[PW-1:FB];
  end

  // saturating accumulate of the pending term
  always_comb begin
    unique case (cmd.acc_sel)
      cgru_pkg::ACC_RR:   acc_cur = acc_rr_r;
      cgru_pkg::ACC_RZ:   acc_cur = acc_rz_r;
      cgru_pkg::ACC_ZZ:   acc_cur = acc_zz_r;
      cgru_pkg::ACC_NONE: acc_cur = '0;
      default:            acc_cur = '0;
    endcase
    acc_sum = $signed({acc_cur[AW-1], acc_cur}) + $signed((AW+1)'(term_r));
    if (acc_sum[AW] != acc_sum[AW-1]) begin
      acc_new = acc_sum[AW] ? {1'b1, {(AW-1){1'b0}}} : {1'b0, {(AW-1){1'b1}}};
    end else begin
      acc_new = acc_sum[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r      <= '0;
      use_weight_r <= 1'b0;
    end else if (cfg_we) begin
      if (cfg_index == cgru_pkg::CFG_ALPHA_STEP) begin
        alpha_r <= cfg_data;
      end else if (cfg_index == cgru_pkg::CFG_USE_WEIGHT) begin
        use_weight_r <= cfg_data[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_in) begin
      r_r    <= resid_in;
      z_r    <= precond_in;
      s_r    <= dir_prod_in;
      ss_r   <= precond_dir_prod_in;
      w_r    <= w_eff;
      last_r <= last_in;
    end
    prod_r <= mul_full[PW-1:0];
    if (cmd.ld_rn)   rn_r   <= ax_sat;
    if (cmd.ld_zn)   zn_r   <= ax_sat;
    if (cmd.ld_prr)  prr_r  <= prod_rnd;
    if (cmd.ld_prz)  prz_r  <= prod_rnd;
    if (cmd.ld_pzz)  pzz_r  <= prod_rnd;
    if (cmd.ld_term) term_r <= prod_rnd;
    if (cmd.ld_out) begin
      resid_out_r   <= rn_r;
      precond_out_r <= zn_r;
      last_out_r    <= last_r;
      sum_rz_r      <= last_r ? acc_rz_r : '0;
      sum_rr_r      <= last_r ? acc_rr_r : '0;
      sum_zz_r      <= last_r ? acc_new  : '0;
    end
  end

  // accumulators: cleared by reset and after the last element is reported
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_rz_r <= '0;
      acc_zz_r <= '0;
      acc_rr_r <= '0;
    end else if (cmd.ld_out && last_r) begin
      acc_rz_r <= '0;
      acc_zz_r <= '0;
      acc_rr_r <= '0;
    end else begin
      if (cmd.acc_sel == cgru_pkg::ACC_RR) acc_rr_r <= acc_new;
      if (cmd.acc_sel == cgru_pkg::ACC_RZ) acc_rz_r <= acc_new;
      if (cmd.acc_sel == cgru_pkg::ACC_ZZ) acc_zz_r <= acc_new;
    end
  end

  assign resid_out   = resid_out_r;
  assign precond_out = precond_out_r;
  assign sum_rz      = sum_rz_r;
  assign sum_zz      = sum_zz_r;
  assign sum_rr      = sum_rr_r;
  assign last_out    = last_out_r;

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for cg_residual_update_three_dots_unit: a directed table, then
// random vectors, checked against a local Q8.24 / Q40.24 predictor or hand-typed results.
// Depends on cgru_pkg and the unit itself; reads no files.
module testbench;
  import cgru_pkg::*;

  localparam int  N_DIR     = 17;
  localparam int  N_SEG     = 10;
  localparam int  SEG_ITEMS = 200;
  localparam int  MAX_PRINT = 40;
  localparam int  DRAIN_CYC = 24;     // comfortably beyond one item's trip through the unit
  localparam real LIMIT_NS  = 10_000_000.0;

  localparam logic signed [DATA_W-1:0] QONE  = 32'sh0100_0000;
  localparam logic signed [DATA_W-1:0] QTWO  = 32'sh0200_0000;
  localparam logic signed [DATA_W-1:0] QHALF = 32'sh0080_0000;
  localparam logic signed [DATA_W-1:0] QMAX  = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] QMIN  = 32'sh8000_0000;
  localparam longint QMAX_L = 64'sd2147483647;
  localparam longint QMIN_L = -64'sd2147483648;
  localparam longint SUM_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint SUM_MIN = 64'sh8000_0000_0000_0000;
  localparam logic [WEIGHT_W-1:0] WALL = 25'h1FF_FFFF;
  localparam logic [WEIGHT_W-1:0] WONE = 25'h100_0000;
  // Index beyond the register map; the unit must ignore such a write
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = '1;

  typedef struct packed {
    logic signed [DATA_W-1:0] resid;
    logic signed [DATA_W-1:0] precond;
    logic signed [DATA_W-1:0] dir;
    logic signed [DATA_W-1:0] pdir;
    logic [WEIGHT_W-1:0]      weight;
    logic                     last;
  } cg_elem_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] resid;
    logic signed [DATA_W-1:0] precond;
    logic signed [ACC_W-1:0]  rz;
    logic signed [ACC_W-1:0]  zz;
    logic signed [ACC_W-1:0]  rr;
    logic                     last;
  } cg_result_t;

  // One directed row: register setting, element, and an optional hand-typed result
  typedef struct packed {
    logic signed [DATA_W-1:0] alpha;
    logic                     wt_on;
    logic signed [DATA_W-1:0] r;
    logic signed [DATA_W-1:0] z;
    logic signed [DATA_W-1:0] s;
    logic signed [DATA_W-1:0] ps;
    logic [WEIGHT_W-1:0]      w;
    logic                     last;
    logic                     typed;
    logic signed [DATA_W-1:0] x_r;
    logic signed [DATA_W-1:0] x_z;
    logic signed [ACC_W-1:0]  x_rz;
    logic signed [ACC_W-1:0]  x_zz;
    logic signed [ACC_W-1:0]  x_rr;
    logic                     x_last;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic signed [DATA_W-1:0]  in_resid_in = '0;
  logic signed [DATA_W-1:0]  in_precond_in = '0;
  logic signed [DATA_W-1:0]  in_dir_prod_in = '0;
  logic signed [DATA_W-1:0]  in_precond_dir_prod_in = '0;
  logic [WEIGHT_W-1:0]       in_node_weight = '0;
  logic                      in_last_in = 1'b0;

  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic signed [DATA_W-1:0]  out_resid_out;
  logic signed [DATA_W-1:0]  out_precond_out;
  logic signed [ACC_W-1:0]   out_sum_rz;
  logic signed [ACC_W-1:0]   out_sum_zz;
  logic signed [ACC_W-1:0]   out_sum_rr;
  logic                      out_last_out;

  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_IDX_W-1:0]      cfg_index = '0;
  logic [DATA_W-1:0]         cfg_data = '0;

  // Predictor state: register copies and the three running dot products
  logic signed [DATA_W-1:0] alpha_q824 = '0;
  logic                     weight_on = 1'b0;
  longint                   dot_rz = 0;
  longint                   dot_zz = 0;
  longint                   dot_rr = 0;

  cg_result_t pending_results [$];
  dir_row_t   dir_tab [N_DIR];
  int         mismatch_cnt = 0;
  int         stall_left = 0;
  bit         no_idle = 1'b0;

  cg_residual_update_three_dots_unit uut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_resid_in            (in_resid_in),
    .in_precond_in          (in_precond_in),
    .in_dir_prod_in         (in_dir_prod_in),
    .in_precond_dir_prod_in (in_precond_dir_prod_in),
    .in_node_weight         (in_node_weight),
    .in_last_in             (in_last_in),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_resid_out          (out_resid_out),
    .out_precond_out        (out_precond_out),
    .out_sum_rz             (out_sum_rz),
    .out_sum_zz             (out_sum_zz),
    .out_sum_rr             (out_sum_rr),
    .out_last_out           (out_last_out),
    .cfg_valid              (cfg_valid),
    .cfg_ready              (cfg_ready),
    .cfg_index              (cfg_index),
    .cfg_data               (cfg_data)
  );

  always #6 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Round a Q.48 value to Q.24: add one half, then floor (arithmetic shift)
  function automatic longint q24_round(input longint v);
    return (v + longint'(HALF_Q24)) >>> FRAC_BITS;
  endfunction

  // x - alpha*y, formed exactly, rounded, then clipped to the 32-bit range
  function automatic logic signed [DATA_W-1:0] axpy_q824(input logic signed [DATA_W-1:0] x,
                                                        input logic signed [DATA_W-1:0] y);
    longint v;
    v = q24_round(longint'(x) * (64'sd1 <<< FRAC_BITS) - longint'(alpha_q824) * longint'(y));
    if (v > QMAX_L) return QMAX;
    if (v < QMIN_L) return QMIN;
    return v[DATA_W-1:0];
  endfunction

  // Weighted term: round a*b to Q.24, scale by the Q1.24 weight, round again
  function automatic longint dot_term(input logic signed [DATA_W-1:0] a,
                                     input logic signed [DATA_W-1:0] b, input longint w);
    return q24_round(q24_round(longint'(a) * longint'(b)) * w);
  endfunction

  // Accumulate with saturation at the signed 64-bit limits
  function automatic longint sum_sat(input longint acc, input longint t);
    longint s;
    s = acc + t;
    if (acc[63] == t[63] && s[63] != acc[63]) return acc[63] ? SUM_MIN : SUM_MAX;
    return s;
  endfunction

  function automatic cg_result_t cg_update_predict(input cg_elem_t e);
    cg_result_t res;
    longint     w;
    w = longint'(ONE_Q24);
    // weights above one are clamped, so only smaller ones take effect
    if (weight_on && e.weight < ONE_Q24) w = longint'(e.weight);
    res.resid   = axpy_q824(e.resid, e.dir);
    res.precond = axpy_q824(e.precond, e.pdir);
    dot_rz = sum_sat(dot_rz, dot_term(res.resid, res.precond, w));
    dot_zz = sum_sat(dot_zz, dot_term(res.precond, res.precond, w));
    dot_rr = sum_sat(dot_rr, dot_term(res.resid, res.resid, w));
    res.last = e.last;
    if (e.last) begin
      // sums include this element; clear for the next vector
      res.rz = dot_rz;
      res.zz = dot_zz;
      res.rr = dot_rr;
      dot_rz = 0;
      dot_zz = 0;
      dot_rr = 0;
    end else begin
      res.rz = '0;
      res.zz = '0;
      res.rr = '0;
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random stall, and comparison with the oldest expectation
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (mismatch_cnt < MAX_PRINT)
      $display("MISMATCH at %0t: %s got %h expected %h", $realtime, what, got, want);
    mismatch_cnt++;
  endtask

  // Draw a fresh stall length after every result transaction; none in flat-out phases
  always @(posedge clk) begin
    if (out_valid === 1'b1 && !out_stall) begin
      stall_left = no_idle ? 0 : $urandom_range(0, 3);
    end else if (stall_left > 0) begin
      stall_left--;
    end
    out_stall <= (stall_left > 0);
  end

  always @(posedge clk) begin : result_check
    cg_result_t want;
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing outstanding", '0, '0);
      end else begin
        want = pending_results.pop_front();
        if (out_resid_out !== want.resid)
          report_mismatch("resid_out", out_resid_out, want.resid);
        if (out_precond_out !== want.precond)
          report_mismatch("precond_out", out_precond_out, want.precond);
        if (out_sum_rz !== want.rz) report_mismatch("sum_rz", out_sum_rz, want.rz);
        if (out_sum_zz !== want.zz) report_mismatch("sum_zz", out_sum_zz, want.zz);
        if (out_sum_rr !== want.rr) report_mismatch("sum_rr", out_sum_rr, want.rr);
        if (out_last_out !== want.last)
          report_mismatch("last_out", out_last_out, want.last);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // Leave cfg_valid high; the caller drops it once the batch of writes is done
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_ALPHA_STEP: alpha_q824 = data;
      CFG_USE_WEIGHT: weight_on = data[0];
      default: ;
    endcase
  endtask

  task automatic program_cfg(input logic signed [DATA_W-1:0] alpha, input bit wt_on,
                             input bit stray);
    logic [DATA_W-1:0] wdata;
    write_reg(CFG_ALPHA_STEP, alpha);
    if (stray) write_reg(CFG_UNUSED_IDX, $urandom);
    // upper bits of the flag write carry noise; only bit 0 counts
    wdata = $urandom;
    wdata[0] = wt_on;
    write_reg(CFG_USE_WEIGHT, wdata);
    cfg_valid <= 1'b0;
  endtask

  // Drop valid and hold until every outstanding result has been taken
  task automatic await_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // Present one element, hold it until accepted, then record its expected result
  task automatic send_elem(input cg_elem_t e, input bit typed, input cg_result_t typed_res);
    int         gap;
    cg_result_t want;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid               <= 1'b1;
    in_resid_in            <= e.resid;
    in_precond_in          <= e.precond;
    in_dir_prod_in         <= e.dir;
    in_precond_dir_prod_in <= e.pdir;
    in_node_weight         <= e.weight;
    in_last_in             <= e.last;
    do @(posedge clk); while (in_stall);
    want = cg_update_predict(e);
    pending_results.push_back(typed ? typed_res : want);
  endtask

  function automatic logic signed [DATA_W-1:0] rand_q824(input int unsigned spread);
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 5))
          0: return QMAX;
          1: return QMIN;
          2: return '0;
          3: return 32'sd1;
          4: return -32'sd1;
          default: return QONE;
        endcase
      end
      1, 2, 3: return $urandom;
      default: return $urandom_range(0, 2 * spread) - spread;
    endcase
  endfunction

  // Well-formed vectors of random length, each closed by a last element
  task automatic pump_vectors(input int n_items);
    int          sent;
    int          len;
    int unsigned spread;
    cg_elem_t    e;
    cg_result_t  unused;
    sent = 0;
    unused = '0;
    while (sent < n_items) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      spread = 1 << (10 + 6 * $urandom_range(0, 3));
      for (int k = 0; k < len; k++) begin
        e.resid   = rand_q824(spread);
        e.precond = rand_q824(spread);
        e.dir     = rand_q824(spread);
        e.pdir    = rand_q824(spread);
        e.weight  = ($urandom_range(0, 7) == 0) ? WEIGHT_W'($urandom)
                                                : WEIGHT_W'($urandom_range(0, ONE_Q24));
        e.last    = (k == len - 1);
        send_elem(e, 1'b0, unused);
      end
      sent += len;
    end
  endtask

  initial begin
    // Columns: alpha, use_weight, r, z, s, S, weight, last, typed,
    //          then the typed result r', z', rz, zz, rr, last_out
    // Reset setting: alpha zero, so r' = r and z' = z
    dir_tab[0]  = '{32'sd0, 1'b0, QONE, QTWO, QMAX, QMIN, 25'd0, 1'b1, 1'b1,
                    QONE, QTWO, 64'sd33554432, 64'sd67108864, 64'sd16777216, 1'b1};
    dir_tab[1]  = '{32'sd0, 1'b0, QMAX, QMIN, 32'sd0, 32'sd0, WALL, 1'b0, 1'b1,
                    QMAX, QMIN, 64'sd0, 64'sd0, 64'sd0, 1'b0};
    dir_tab[2]  = '{32'sd0, 1'b0, QMIN, QMAX, -32'sd1, 32'sd1, 25'd0, 1'b1, 1'b0,
                    32'sd0, 32'sd0, 64'sd0, 64'sd0, 64'sd0, 1'b0};
    // Alpha one, weighted
    dir_tab[3]  = '{QONE, 1'b1, 32'sd0, 32'sd0, QONE, -QONE, WONE, 1'b1, 1'b1,
                    -QONE, QONE, -64'sd16777216, 64'sd16777216, 64'sd16777216, 1'b1};
    // Both updates saturate; zero weight kills every term
    dir_tab[4]  = '{QONE, 1'b1, QMAX, QMIN, QMIN, QMAX, 25'd0, 1'b1, 1'b1,
                    QMAX, QMIN, 64'sd0, 64'sd0, 64'sd0, 1'b1};
    // Weights above one clamp to one
    dir_tab[5]  = '{QONE, 1'b1, QONE, QONE, 32'sd0, 32'sd0, WALL, 1'b1, 1'b1,
                    QONE, QONE, 64'sd16777216, 64'sd16777216, 64'sd16777216, 1'b1};
    dir_tab[6]  = '{QONE, 1'b1, QONE, QONE, 32'sd0, 32'sd0, 25'h100_0001, 1'b1, 1'b1,
                    QONE, QONE, 64'sd16777216, 64'sd16777216, 64'sd16777216, 1'b1};
    dir_tab[7]  = '{QONE, 1'b1, QONE, QONE, 32'sd0, 32'sd0, 25'h080_0000, 1'b0, 1'b0,
                    32'sd0, 32'sd0, 64'sd0, 64'sd0, 64'sd0, 1'b0};
    dir_tab[8]  = '{QONE, 1'b1, QTWO, -QONE, QONE, QONE, 25'h0FF_FFFF, 1'b1, 1'b0,
                    32'sd0, 32'sd0, 64'sd0, 64'sd0, 64'sd0, 1'b0};
    // Most negative alpha, unweighted: rounding of single-LSB products
    dir_tab[9]  = '{QMIN, 1'b0, 32'sd0, 32'sd0, 32'sd1, -32'sd1, 25'd0, 1'b0, 1'b0,
                    32'sd0, 32'sd0, 64'sd0, 64'sd0, 64'sd0, 1'b0};
    dir_tab[10] = '{QMIN, 1'b0, QMIN, QMAX, QMAX, QMIN, WALL, 1'b0, 1'b0,
                    32'sd0, 32'sd0, 64'sd0, 64'sd0, 64'sd0, 1'b0};
    dir_tab[11] = '{QMIN, 1'b0, QHALF, -QHALF, 32'sd0, 32'sd0, 25'd0, 1'b1, 1'b0,
                    32'sd0, 32'sd0, 64'sd0, 64'sd0, 64'sd0, 1'b0};
    // Most positive alpha, weighted
    dir_tab[12] = '{QMAX, 1'b1, 32'sd0, 32'sd0, 32'sd1, -32'sd1, WONE, 1'b0, 1'b0,
                    32'sd0, 32'sd0, 64'sd0, 64'sd0, 64'sd0, 1'b0};
    dir_tab[13] = '{QMAX, 1'b1, QMAX, QMIN, -32'sd1, 32'sd1, 25'h0AA_AAAA, 1'b0, 1'b0,
                    32'sd0, 32'sd0, 64'sd0, 64'sd0, 64'sd0, 1'b0};
    dir_tab[14] = '{QMAX, 1'b1, 32'sh5555_5555, 32'shAAAA_AAAA, 32'sh0000_0100,
                    32'shFFFF_FF00, 25'h155_5555, 1'b1, 1'b0,
                    32'sd0, 32'sd0, 64'sd0, 64'sd0, 64'sd0, 1'b0};
    // All-zero element; then a minus-one LSB whose square rounds away to nothing
    dir_tab[15] = '{32'sd0, 1'b1, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 25'd0, 1'b1, 1'b1,
                    32'sd0, 32'sd0, 64'sd0, 64'sd0, 64'sd0, 1'b1};
    dir_tab[16] = '{32'sd0, 1'b0, -32'sd1, -32'sd1, 32'sd0, 32'sd0, 25'd0, 1'b1, 1'b1,
                    -32'sd1, -32'sd1, 64'sd0, 64'sd0, 64'sd0, 1'b1};
  end

  // Main sequence
  initial begin : stimulus
    dir_row_t          row;
    cg_elem_t          e;
    cg_result_t        tres;
    logic signed [DATA_W-1:0] alpha;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table: reprogram at the first row or a setting change, with the unit idle
    for (int i = 0; i < N_DIR; i++) begin
      row = dir_tab[i];
      if (i == 0 || row.alpha != alpha_q824 || row.wt_on != weight_on) begin
        await_idle();
        program_cfg(row.alpha, row.wt_on, i == 0);
      end
      e    = '{row.r, row.z, row.s, row.ps, row.w, row.last};
      tres = '{row.x_r, row.x_z, row.x_rz, row.x_zz, row.x_rr, row.x_last};
      send_elem(e, row.typed, tres);
    end

    // Random phases: alpha at extremes, zero, one, then random; weighting alternates
    for (int seg = 0; seg < N_SEG; seg++) begin
      case (seg)
        0: alpha = QMIN;
        1: alpha = QMAX;
        2: alpha = '0;
        3: alpha = QONE;
        default: alpha = $urandom_range(0, 1) ? DATA_W'($urandom)
                                              : DATA_W'($urandom_range(0, 1 << 26) - (1 << 25));
      endcase
      await_idle();
      program_cfg(alpha, seg[0], $urandom_range(0, 2) == 0);
      // every fourth phase runs flat out on both sides
      no_idle = (seg % 4 == 2);
      pump_vectors(SEG_ITEMS);
    end

    // Drain, then allow stray results time to show up
    await_idle();
    repeat (DRAIN_CYC) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #(LIMIT_NS);
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/cgru_pkg.sv
design/cgru_ctrl.sv
design/cgru_dp.sv
design/cg_residual_update_three_dots_unit.sv
verif/testbench.sv
